>>> rtl/file_block_packet_framer_core_assert.svh
// Assertion macros shared by the framer RTL.
// Each macro expects i_clk and i_rst_n in the module that uses it.
`ifndef FILE_BLOCK_PACKET_FRAMER_CORE_ASSERT_SVH
`define FILE_BLOCK_PACKET_FRAMER_CORE_ASSERT_SVH

// Plain invariant, checked at every clock edge out of reset.
`define FBPF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define FBPF_ASSERT_IMPL(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

>>> rtl/fbpf_pkg.sv
// Shared types and constants of the file block packet framer.
// No dependencies.
`timescale 1ns / 1ps

package fbpf_pkg;

    // Block size in bytes; must be a power of two between 4 and 65536.
    localparam int BLOCK_SIZE = 1024;
    localparam int BLK_LOG2   = $clog2(BLOCK_SIZE);
    localparam int BLK_W      = BLK_LOG2 + 1;   // holds 0..BLOCK_SIZE
    localparam int PW_W       = BLK_W - 1;      // payload words of one block

    localparam int HDR_WORDS  = 4;

    // Job queue between front and back; depth must be a power of two.
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_FLAG  = 2'd1,
        CMD_DATA  = 2'd2,
        CMD_CLOSE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BUSY     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_MISMATCH = 2'd3
    } t_status;

    // Header word positions
    localparam logic [1:0] HW_IDENT  = 2'd0;
    localparam logic [1:0] HW_LENGTH = 2'd1;
    localparam logic [1:0] HW_OFFSET = 2'd2;
    localparam logic [1:0] HW_PAYLD  = 2'd3;

    // One unit of work for the back end: a status, or a byte's output words.
    typedef struct packed {
        logic              is_status;
        t_status           status;
        logic              hdr;
        logic [31:0]       ident;
        logic [31:0]       len_words;
        logic [31:0]       pos_words;
        logic [PW_W-1:0]   blk_words;
        logic              pay;
        logic [31:0]       pay_word;
        logic              last;
    } t_job;

    typedef struct packed {
        logic        is_status;
        t_status     status;
        logic [31:0] word;
        logic        last;
    } t_result;

endpackage

>>> rtl/fbpf_front.sv
// Front end: takes commands and bytes, tracks file and block state, packs
// bytes into words and posts jobs to the queue. Depends on fbpf_pkg.
`timescale 1ns / 1ps
`include "file_block_packet_framer_core_assert.svh"

module fbpf_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic                 i_full,
    input  logic [1:0]           i_cmd,
    input  logic [31:0]          i_file_ident,
    input  logic [31:0]          i_file_bytes,
    input  logic                 i_flags_used,
    input  logic [22:0]          i_flag_count,
    input  logic [7:0]           i_keep_flag,
    input  logic [7:0]           i_data_byte,
    output logic                 o_job_wr,
    output fbpf_pkg::t_job       o_job
);
    import fbpf_pkg::*;

    logic              r_active, n_active;
    logic              r_flag_mode, n_flag_mode;
    logic [31:0]       r_ident, n_ident;
    logic [31:0]       r_len_words, n_len_words;
    logic [31:0]       r_pos, n_pos;
    logic [31:0]       r_remain, n_remain;
    logic [BLK_W-1:0]  r_bib, n_bib;
    logic              r_keep, n_keep;
    logic [23:0]       r_buf, n_buf;
    logic [1:0]        r_cnt, n_cnt;

    logic              accept;
    logic [32:0]       blocks;
    logic [32:0]       fwords;
    logic [BLK_W-1:0]  blk;
    logic [BLK_W:0]    blk_sum;
    logic [BLK_W-1:0]  bib_inc;
    logic              block_end;
    logic              last_block;
    logic [31:0]       packed_word;
    t_job              job;
    logic              job_wr;

    assign accept     = i_push && !i_full;
    assign blocks     = ({1'b0, i_file_bytes} + 33'(BLOCK_SIZE - 1)) >> BLK_LOG2;
    assign fwords     = ({1'b0, i_file_bytes} + 33'd3) >> 2;
    assign blk        = (r_remain >= 32'(BLOCK_SIZE)) ? BLK_W'(BLOCK_SIZE)
                                                      : r_remain[BLK_W-1:0];
    assign blk_sum    = {1'b0, blk} + (BLK_W + 1)'(3);
    assign bib_inc    = r_bib + BLK_W'(1);
    assign block_end  = bib_inc >= blk;
    assign last_block = r_remain <= 32'(BLOCK_SIZE);

    // Left-align the pending bytes plus this one, zero padded.
    always_comb begin
        unique case (r_cnt)
            2'd0: packed_word = {i_data_byte, 24'd0};
            2'd1: packed_word = {r_buf[7:0], i_data_byte, 16'd0};
            2'd2: packed_word = {r_buf[15:0], i_data_byte, 8'd0};
            2'd3: packed_word = {r_buf[23:0], i_data_byte};
        endcase
    end

    always_comb begin
        n_active    = r_active;
        n_flag_mode = r_flag_mode;
        n_ident     = r_ident;
        n_len_words = r_len_words;
        n_pos       = r_pos;
        n_remain    = r_remain;
        n_bib       = r_bib;
        n_keep      = r_keep;
        n_buf       = r_buf;
        n_cnt       = r_cnt;

        job           = '0;
        job.ident     = r_ident;
        job.len_words = r_len_words;
        job.pos_words = {2'd0, r_pos[31:2]};
        job.blk_words = blk_sum[BLK_W:2];
        job.pay_word  = packed_word;
        job_wr        = 1'b0;

        unique case (t_cmd'(i_cmd))
            CMD_START: begin
                job.is_status = 1'b1;
                job_wr        = 1'b1;
                priority if (r_active) begin
                    job.status = ST_BUSY;
                end else if (i_file_bytes == 32'd0) begin
                    job.status = ST_EMPTY;
                end else if (i_flags_used && (33'(i_flag_count) != blocks)) begin
                    job.status = ST_MISMATCH;
                end else begin
                    job.status  = ST_OK;
                    n_active    = 1'b1;
                    n_flag_mode = i_flags_used;
                    n_ident     = i_file_ident;
                    n_len_words = fwords[31:0];
                    n_pos       = '0;
                    n_remain    = i_file_bytes;
                    n_bib       = '0;
                    n_keep      = 1'b1;
                    n_buf       = '0;
                    n_cnt       = '0;
                end
            end
            CMD_FLAG: begin
                if (r_active && r_flag_mode && (r_bib == '0)) begin
                    n_keep = |i_keep_flag;
                end
            end
            CMD_DATA: begin
                if (r_active) begin
                    job.hdr  = r_keep && (r_bib == '0);
                    n_bib    = bib_inc;
                    if (r_keep) begin
                        if ((r_cnt == 2'd3) || block_end) begin
                            job.pay  = 1'b1;
                            job.last = block_end;
                            n_buf    = '0;
                            n_cnt    = '0;
                        end else begin
                            n_buf = {r_buf[15:0], i_data_byte};
                            n_cnt = r_cnt + 2'd1;
                        end
                    end
                    // post a job only when this byte yields words
                    job_wr = job.hdr || job.pay;
                    if (block_end) begin
                        n_bib  = '0;
                        n_buf  = '0;
                        n_cnt  = '0;
                        if (last_block) begin
                            // final block in: drop back to idle
                            n_active    = 1'b0;
                            n_flag_mode = 1'b0;
                            n_pos       = '0;
                            n_remain    = '0;
                            n_keep      = 1'b0;
                        end else begin
                            n_pos    = r_pos + 32'(BLOCK_SIZE);
                            n_remain = r_remain - 32'(BLOCK_SIZE);
                            n_keep   = 1'b1;
                        end
                    end
                end
            end
            CMD_CLOSE: begin
                n_active    = 1'b0;
                n_flag_mode = 1'b0;
                n_pos       = '0;
                n_remain    = '0;
                n_bib       = '0;
                n_keep      = 1'b0;
                n_buf       = '0;
                n_cnt       = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_flag_mode <= 1'b0;
            r_pos       <= '0;
            r_remain    <= '0;
            r_bib       <= '0;
            r_keep      <= 1'b0;
            r_buf       <= '0;
            r_cnt       <= '0;
        end else if (accept) begin
            r_active    <= n_active;
            r_flag_mode <= n_flag_mode;
            r_pos       <= n_pos;
            r_remain    <= n_remain;
            r_bib       <= n_bib;
            r_keep      <= n_keep;
            r_buf       <= n_buf;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ident     <= n_ident;
            r_len_words <= n_len_words;
        end
    end

    assign o_job_wr = accept && job_wr;
    assign o_job    = job;

    `FBPF_ASSERT_IMPL(a_idle_clean, !r_active, (r_bib == '0) && (r_cnt == '0), "stale block state")

endmodule

>>> rtl/fbpf_queue.sv
// Short job queue between the front and back ends.
// Depends on fbpf_pkg for the job type and depth.
`timescale 1ns / 1ps
`include "file_block_packet_framer_core_assert.svh"

module fbpf_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  fbpf_pkg::t_job   i_data,
    input  logic             i_rd,
    output logic             o_full,
    output logic             o_empty,
    output fbpf_pkg::t_job   o_head
);
    import fbpf_pkg::*;

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;

    logic            do_wr;
    logic            do_rd;

    assign o_full  = r_count == (Q_AW + 1)'(Q_DEPTH);
    assign o_empty = r_count == '0;
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            unique case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + (Q_AW + 1)'(1);
                2'b01:   r_count <= r_count - (Q_AW + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `FBPF_ASSERT(a_count_range, r_count <= (Q_AW + 1)'(Q_DEPTH), "queue count past depth")
    `FBPF_ASSERT_IMPL(a_no_overrun, i_wr, !o_full, "job written into a full queue")

endmodule

>>> rtl/fbpf_back.sv
// Back end: expands queued jobs into status and packet words, one word a cycle
// while the registered output stage is free or popped. Depends on fbpf_pkg.
`timescale 1ns / 1ps
`include "file_block_packet_framer_core_assert.svh"

module fbpf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  fbpf_pkg::t_job     i_q_head,
    output logic               o_q_rd,
    input  logic               i_pop,
    output logic               o_valid,
    output fbpf_pkg::t_result  o_res
);
    import fbpf_pkg::*;

    logic [2:0] r_step, n_step;
    logic       r_out_valid;
    t_result    r_res;

    t_result    res;
    logic       done;
    logic       advance;

    assign advance = !i_q_empty && (!r_out_valid || i_pop);

    always_comb begin
        res  = '0;
        done = 1'b1;
        if (i_q_head.is_status) begin
            res.is_status = 1'b1;
            res.status    = i_q_head.status;
        end else if (i_q_head.hdr && (r_step < 3'(HDR_WORDS))) begin
            unique case (r_step[1:0])
                HW_IDENT:  res.word = i_q_head.ident;
                HW_LENGTH: res.word = i_q_head.len_words;
                HW_OFFSET: res.word = i_q_head.pos_words;
                HW_PAYLD:  res.word = 32'(i_q_head.blk_words);
            endcase
            done = (r_step[1:0] == HW_PAYLD) && !i_q_head.pay;
        end else begin
            res.word = i_q_head.pay_word;
            res.last = i_q_head.last;
        end
        n_step = done ? 3'd0 : r_step + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_step      <= n_step;
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the word until it is taken.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= res;
        end
    end

    assign o_q_rd  = advance && done;
    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    `FBPF_ASSERT_IMPL(a_mid_job_head, r_step != 3'd0, !i_q_empty, "job head lost mid expansion")
    `FBPF_ASSERT(a_step_range, r_step <= 3'(HDR_WORDS), "word step out of range")

endmodule

>>> rtl/file_block_packet_framer_core.sv
// Top level of the file block packet framer: front end, job queue, back end.
// Depends on fbpf_pkg, fbpf_front, fbpf_queue and fbpf_back.
//
//  channel   handshake          payload
//  input     push / full        i_cmd, i_file_ident, i_file_bytes, i_flags_used,
//                               i_flag_count, i_keep_flag, i_data_byte
//  result    empty / pop        o_is_status, o_status, o_word, o_packet_last
//
// One input word is taken per cycle while the job queue has room.
// The back end sends one result word per cycle while the receiver pops; the
// first byte of a kept block costs four header words, five if it ends the block,
// absorbed by the four-entry job queue since later bytes yield a word only every
// fourth byte. A result is registered in the back end's output stage.
// Reset is synchronous; there is no clearing pass.
`timescale 1ns / 1ps

module file_block_packet_framer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_file_ident,
    input  logic [31:0] i_file_bytes,
    input  logic        i_flags_used,
    input  logic [22:0] i_flag_count,
    input  logic [7:0]  i_keep_flag,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic        o_is_status,
    output logic [1:0]  o_status,
    output logic [31:0] o_word,
    output logic        o_packet_last
);
    import fbpf_pkg::*;

    t_job    job;
    logic    job_wr;
    t_job    q_head;
    logic    q_empty;
    logic    q_rd;
    logic    out_valid;
    t_result res;

    fbpf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_cmd        (i_cmd),
        .i_file_ident (i_file_ident),
        .i_file_bytes (i_file_bytes),
        .i_flags_used (i_flags_used),
        .i_flag_count (i_flag_count),
        .i_keep_flag  (i_keep_flag),
        .i_data_byte  (i_data_byte),
        .o_job_wr     (job_wr),
        .o_job        (job)
    );

    fbpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_wr),
        .i_data  (job),
        .i_rd    (q_rd),
        .o_full  (full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    fbpf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_valid   (out_valid),
        .o_res     (res)
    );

    assign empty         = !out_valid;
    assign o_is_status   = res.is_status;
    assign o_status      = res.status;
    assign o_word        = res.word;
    assign o_packet_last = res.last;

endmodule

>>> tb/file_block_packet_framer_checker.sv
// Checker for the file block packet framer: predicts every result word from the
// accepted input words and compares the popped words against the prediction.
// Depends on fbpf_pkg only.
`timescale 1ns / 1ps

module file_block_packet_framer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_file_ident,
    input  logic [31:0] i_file_bytes,
    input  logic        i_flags_used,
    input  logic [22:0] i_flag_count,
    input  logic [7:0]  i_keep_flag,
    input  logic [7:0]  i_data_byte,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic        i_is_status,
    input  logic [1:0]  i_status,
    input  logic [31:0] i_word,
    input  logic        i_packet_last,
    output int          o_fail_count,
    output int          o_pending
);
    import fbpf_pkg::*;

    // Framer state as predicted
    logic             fr_active;
    logic             fr_flag_mode;
    logic [31:0]      fr_ident;
    logic [31:0]      fr_length;
    logic [31:0]      fr_offset;
    logic [BLK_W-1:0] fr_taken;
    logic             fr_keep;
    logic [23:0]      fr_pack;
    logic [1:0]       fr_pack_n;

    t_result          framed_words[$];
    int               fail_tally = 0;

    function automatic logic [31:0] word_count(input logic [63:0] nbytes);
        logic [63:0] w;
        w = (nbytes + 64'd3) >> 2;
        return w[31:0];
    endfunction

    task automatic clear_framer();
        fr_active    = 1'b0;
        fr_flag_mode = 1'b0;
        fr_ident     = '0;
        fr_length    = '0;
        fr_offset    = '0;
        fr_taken     = '0;
        fr_keep      = 1'b0;
        fr_pack      = '0;
        fr_pack_n    = '0;
    endtask

    task automatic add_word(input logic is_st, input t_status st, input logic [31:0] w,
                            input logic last);
        t_result r;
        r.is_status = is_st;
        r.status    = st;
        r.word      = w;
        r.last      = last;
        framed_words.push_back(r);
    endtask

    task automatic frame_input(input t_cmd c, input logic [31:0] ident,
                               input logic [31:0] nbytes, input logic fu,
                               input logic [22:0] fc, input logic [7:0] kf,
                               input logic [7:0] db);
        logic [63:0] blocks;
        logic [63:0] remaining;
        logic [63:0] blk;
        logic [63:0] taken64;
        logic [63:0] next_off;
        logic [31:0] acc;
        logic [2:0]  cnt;
        logic        block_end;
        t_status     st;
        case (c)
            CMD_START: begin
                blocks = ({32'd0, nbytes} + 64'(BLOCK_SIZE - 1)) / 64'(BLOCK_SIZE);
                if (fr_active) begin
                    st = ST_BUSY;
                end else if (nbytes == 32'd0) begin
                    st = ST_EMPTY;
                end else if (fu && {41'd0, fc} != blocks) begin
                    st = ST_MISMATCH;
                end else begin
                    clear_framer();
                    fr_active    = 1'b1;
                    fr_flag_mode = fu;
                    fr_ident     = ident;
                    fr_length    = nbytes;
                    fr_keep      = 1'b1;
                    st           = ST_OK;
                end
                add_word(1'b1, st, 32'd0, 1'b0);
            end
            CMD_FLAG: begin
                // only before the first byte of a block, last flag wins
                if (fr_active && fr_flag_mode && fr_taken == '0)
                    fr_keep = (kf != 8'd0);
            end
            CMD_CLOSE: begin
                clear_framer();
            end
            default: begin
                if (fr_active) begin
                    remaining = {32'd0, fr_length} - {32'd0, fr_offset};
                    blk = (remaining < 64'(BLOCK_SIZE)) ? remaining : 64'(BLOCK_SIZE);
                    if (fr_keep && fr_taken == '0) begin
                        add_word(1'b0, ST_OK, fr_ident, 1'b0);
                        add_word(1'b0, ST_OK, word_count({32'd0, fr_length}), 1'b0);
                        add_word(1'b0, ST_OK, word_count({32'd0, fr_offset}), 1'b0);
                        add_word(1'b0, ST_OK, word_count(blk), 1'b0);
                    end
                    fr_taken  = fr_taken + BLK_W'(1);
                    taken64   = 64'(fr_taken);
                    block_end = (taken64 >= blk);
                    if (fr_keep) begin
                        acc = {fr_pack, db};
                        cnt = {1'b0, fr_pack_n} + 3'd1;
                        if (cnt == 3'(HDR_WORDS) || block_end) begin
                            // left-align a short final word, zero padded
                            add_word(1'b0, ST_OK, acc << (8 * (HDR_WORDS - cnt)), block_end);
                            fr_pack   = '0;
                            fr_pack_n = '0;
                        end else begin
                            fr_pack   = acc[23:0];
                            fr_pack_n = cnt[1:0];
                        end
                    end
                    if (block_end) begin
                        next_off = {32'd0, fr_offset} + 64'(BLOCK_SIZE);
                        if (next_off >= {32'd0, fr_length}) begin
                            clear_framer();
                        end else begin
                            fr_offset = next_off[31:0];
                            fr_taken  = '0;
                            fr_pack   = '0;
                            fr_pack_n = '0;
                            fr_keep   = 1'b1;
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            fail_tally++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result head;
        if (!i_rst_n) begin
            clear_framer();
            framed_words.delete();
        end else begin
            if (i_push && !i_full)
                frame_input(t_cmd'(i_cmd), i_file_ident, i_file_bytes, i_flags_used,
                            i_flag_count, i_keep_flag, i_data_byte);
            if (i_pop && !i_empty) begin
                if (framed_words.size() == 0) begin
                    $error("o_word: unexpected result word 0x%0h", i_word);
                    fail_tally++;
                end else begin
                    head = framed_words.pop_front();
                    check_field("o_is_status", 32'(head.is_status), 32'(i_is_status));
                    check_field("o_status", 32'(head.status), 32'(i_status));
                    check_field("o_word", head.word, i_word);
                    check_field("o_packet_last", 32'(head.last), 32'(i_packet_last));
                end
            end
        end
        o_fail_count <= fail_tally;
        o_pending    <= framed_words.size();
    end

endmodule

>>> tb/tb_file_block_packet_framer_core.sv
// Testbench top for the file block packet framer: clock, reset, stimulus, verdict.
// Depends on fbpf_pkg, the framer RTL and file_block_packet_framer_checker.
`timescale 1ns / 1ps

module tb_file_block_packet_framer_core;
    import fbpf_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        push         = 1'b0;
    logic        full;
    logic [1:0]  i_cmd        = CMD_CLOSE;
    logic [31:0] i_file_ident = '0;
    logic [31:0] i_file_bytes = '0;
    logic        i_flags_used = 1'b0;
    logic [22:0] i_flag_count = '0;
    logic [7:0]  i_keep_flag  = '0;
    logic [7:0]  i_data_byte  = '0;
    logic        empty;
    logic        pop          = 1'b0;
    logic        o_is_status;
    logic [1:0]  o_status;
    logic [31:0] o_word;
    logic        o_packet_last;

    int fail_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_ack       = 0;
    int hold_left      = 0;
    int words_sent     = 0;
    int cycle_cnt      = 0;

    file_block_packet_framer_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_cmd         (i_cmd),
        .i_file_ident  (i_file_ident),
        .i_file_bytes  (i_file_bytes),
        .i_flags_used  (i_flags_used),
        .i_flag_count  (i_flag_count),
        .i_keep_flag   (i_keep_flag),
        .i_data_byte   (i_data_byte),
        .empty         (empty),
        .pop           (pop),
        .o_is_status   (o_is_status),
        .o_status      (o_status),
        .o_word        (o_word),
        .o_packet_last (o_packet_last)
    );

    file_block_packet_framer_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_cmd         (i_cmd),
        .i_file_ident  (i_file_ident),
        .i_file_bytes  (i_file_bytes),
        .i_flags_used  (i_flags_used),
        .i_flag_count  (i_flag_count),
        .i_keep_flag   (i_keep_flag),
        .i_data_byte   (i_data_byte),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_is_status   (o_is_status),
        .i_status      (o_status),
        .i_word        (o_word),
        .i_packet_last (o_packet_last),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            pop       <= 1'b0;
        end else if (hold_ack != hold_req) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            pop       <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one word and hold it until taken; push stays high into the next call
    task automatic put_item(input t_cmd c, input logic [31:0] ident, input logic [31:0] nbytes,
                            input logic fu, input logic [22:0] fc, input logic [7:0] kf,
                            input logic [7:0] db);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_cmd        <= c;
        i_file_ident <= ident;
        i_file_bytes <= nbytes;
        i_flags_used <= fu;
        i_flag_count <= fc;
        i_keep_flag  <= kf;
        i_data_byte  <= db;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_start(input logic [31:0] ident, input logic [31:0] nbytes,
                              input logic fu, input logic [22:0] fc);
        put_item(CMD_START, ident, nbytes, fu, fc, 8'($urandom), 8'($urandom));
    endtask

    task automatic send_flag(input logic [7:0] kf);
        put_item(CMD_FLAG, $urandom, $urandom, 1'($urandom), 23'($urandom), kf,
                 8'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] db);
        put_item(CMD_DATA, $urandom, $urandom, 1'($urandom), 23'($urandom), 8'($urandom),
                 db);
    endtask

    task automatic send_close();
        put_item(CMD_CLOSE, $urandom, $urandom, 1'($urandom), 23'($urandom), 8'($urandom),
                 8'($urandom));
    endtask

    function automatic logic [7:0] random_keep();
        logic [7:0] kf;
        kf = ($urandom_range(2) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        return kf;
    endfunction

    // Whole file; keeps selects per block, hold_at starts the long hold-off
    task automatic run_long_file(input int nbytes, input logic fu, input logic [1:0] keeps,
                                 input int hold_at);
        int         k;
        logic [7:0] kf;
        send_start($urandom, 32'(nbytes), fu, 23'((nbytes + BLOCK_SIZE - 1) / BLOCK_SIZE));
        for (k = 0; k < nbytes; k++) begin
            if (fu && (k % BLOCK_SIZE) == 0) begin
                kf = keeps[k / BLOCK_SIZE] ? 8'($urandom_range(1, 255)) : 8'h00;
                send_flag(kf);
            end
            if (k == hold_at)
                hold_req <= hold_req + 1;
            send_byte(8'($urandom));
        end
    endtask

    task automatic run_random_file();
        int   r;
        int   k;
        int   nbytes;
        int   cut;
        logic fu;
        r = $urandom_range(99);
        if (r < 8) begin
            // out-of-place words and starts with arbitrary fields
            case ($urandom_range(3))
                0: send_byte(8'($urandom));
                1: send_flag(8'($urandom));
                2: send_close();
                default: begin
                    send_start($urandom, $urandom, 1'($urandom_range(1)), 23'($urandom));
                    repeat ($urandom_range(0, 6)) send_byte(8'($urandom));
                    send_close();
                end
            endcase
        end else if (r < 15) begin
            // wrong flag count, then bytes that find the block idle
            nbytes = $urandom_range(1, 12);
            send_start($urandom, 32'(nbytes), 1'b1,
                       $urandom_range(1) ? 23'd0 : 23'($urandom));
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end else begin
            nbytes = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            fu     = 1'($urandom_range(1));
            cut    = ($urandom_range(19) == 0) ? $urandom_range(0, nbytes - 1) : nbytes;
            send_start($urandom, 32'(nbytes), fu, fu ? 23'd1 : 23'($urandom));
            if (fu)
                repeat ($urandom_range(0, 2)) send_flag(random_keep());
            for (k = 0; k < cut; k++) begin
                if ($urandom_range(24) == 0)
                    send_flag(random_keep());
                if ($urandom_range(29) == 0)
                    send_start($urandom, $urandom, 1'($urandom_range(1)), 23'($urandom));
                send_byte(8'($urandom));
            end
            // abandon the packet part way
            if (cut < nbytes)
                send_close();
        end
    endtask

    initial begin : stimulus
        int phase;
        int target;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Words while idle are dropped
        send_byte(8'hFF);
        send_flag(8'hFF);
        send_close();
        // Rejected starts: empty file, flag count mismatch
        send_start(32'h1234_5678, 32'd0, 1'b0, 23'd0);
        send_start(32'hFFFF_FFFF, 32'd5, 1'b1, 23'h7F_FFFF);
        // Largest file with the largest flag count, then busy
        send_start(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 23'd4194304);
        send_start(32'h0, 32'd8, 1'b0, 23'd0);
        // Last flag before the first byte wins
        send_flag(8'hFF);
        send_flag(8'h00);
        send_flag(8'h01);
        send_byte(8'hFF);
        send_flag(8'h00);
        send_byte(8'h00);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'h3C);
        send_close();
        // One-byte file, flag count ignored outside flag mode
        send_start(32'h0, 32'd1, 1'b0, 23'h7F_FFFF);
        send_byte(8'h80);
        // Only block dropped: the block must still return to idle
        send_start(32'hA5A5_5A5A, 32'd3, 1'b1, 23'd1);
        send_flag(8'h00);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);
        send_start(32'h0F0F_F0F0, 32'd2, 1'b0, 23'd0);
        send_byte(8'h7F);
        send_byte(8'hFE);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct  = 80;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 80;
                end
                default: begin
                    send_idle_pct  = 12;
                    recv_stall_pct <= 12;
                end
            endcase
            case (phase)
                // fill the block while the receiver holds off
                0: run_long_file(24, 1'b0, 2'b11, 2);
                1: run_long_file(19, 1'b1, 2'b10, -1);
                2: run_long_file(16, 1'b1, 2'b00, -1);
                default: run_long_file(21, 1'b1, 2'b01, -1);
            endcase
            target = words_sent + 45;
            while (words_sent < target)
                run_random_file();
        end

        send_idle_pct  = 0;
        recv_stall_pct <= 0;
        push           <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
